>>> hdl/pae_pkg.sv
// Package for the particle attractor Euler step core.
// Holds shared constants, the register index codes, the beat payload types and the width functions.
// No dependencies.
package pae_pkg;

  localparam int NUM_SLOTS       = 4;
  localparam int MAX_TOUCHES_DEF = 4;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int REACH_PIX  = 200;
  localparam int REACH_SQ   = 40000;
  localparam int GAIN_NEAR  = 131072;
  localparam int GAIN_SPAN  = 130417;
  localparam int ROUND_HALF = 32768;
  localparam int Q16        = 16;

  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  localparam logic [15:0] FRICTION_RST = 16'd3277;
  localparam logic [15:0] TSTEP_RST    = 16'd1092;
  localparam logic [15:0] HWEIGHT_RST  = 16'd58982;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FRICTION,
    CFG_TSTEP,
    CFG_HWEIGHT,
    CFG_TENABLE,
    CFG_SLOT0,
    CFG_SLOT1,
    CFG_SLOT2,
    CFG_SLOT3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] home_x;
    logic signed [31:0] home_y;
    logic [15:0]        home_pull;
    logic [15:0]        touch_pull;
  } pae_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
  } pae_out_t;

  function automatic int diff_w(input int f);
    return ((16 + f > 31) ? 16 + f : 31) + 2;
  endfunction

  function automatic int acc_w(input int f);
    return diff_w(f) + 5;
  endfunction

endpackage

>>> hdl/pae_stream_if.sv
// Valid/ready stream interface used for the particle and result channels.
// The payload type is set by the instantiating level; no other dependencies.
interface pae_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/pae_cell.sv
// One touch slot cell: computes the attractor pull of its slot and adds it to the
// running acceleration, passing the particle to the next cell. Uses pae_pkg.
module pae_cell #(
  parameter int FRAC_BITS = pae_pkg::FRAC_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             en,
  input  logic                                             slot_en,
  input  logic [31:0]                                      slot,
  input  logic                                             in_v,
  input  pae_pkg::pae_in_t                                 in_p,
  input  logic signed [pae_pkg::acc_w(FRAC_BITS)-1:0]      in_acc [3],
  output logic                                             out_v,
  output pae_pkg::pae_in_t                                 out_p,
  output logic signed [pae_pkg::acc_w(FRAC_BITS)-1:0]      out_acc [3]
);

  localparam int F      = FRAC_BITS;
  localparam int DW     = pae_pkg::diff_w(F);
  localparam int AW     = pae_pkg::acc_w(F);
  localparam int SQW    = 8 + F;
  localparam int D2W    = 16 + F;
  localparam int TW     = 17;
  localparam int GW     = 18;
  localparam int MW     = DW + 2;
  localparam int S_DIV  = 3;
  localparam int S_GAIN = S_DIV + 1;
  localparam int S_M1   = S_GAIN + 1;
  localparam int S_M2   = S_M1 + 1;
  localparam int S_ACC  = S_M2 + 1;
  localparam int L      = S_ACC + 1;

  localparam logic [DW-1:0]  REACH = DW'(pae_pkg::REACH_PIX) << F;
  localparam logic [D2W-1:0] LO    = D2W'(1) << F;
  localparam logic [D2W-1:0] HI    = D2W'(pae_pkg::REACH_SQ) << F;

  // Division by 40000 is a shift by 6 and a multiply by the rounded-up
  // reciprocal of 625, exact for every clamped distance.
  localparam int          PRE   = 6;
  localparam int          RSH   = 35;
  localparam logic [25:0] RECIP = 26'd54975582;

  function automatic logic signed [MW+1:0] mq(input logic signed [MW-1:0] a,
                                              input logic [GW-1:0] b);
    logic [MW-1:0]    m;
    logic [MW+GW-1:0] p;
    m = a[MW-1] ? MW'(-a) : MW'(a);
    p = (MW+GW)'(m) * (MW+GW)'(b) + (MW+GW)'(pae_pkg::ROUND_HALF);
    return a[MW-1] ? -$signed({1'b0, p[MW+pae_pkg::Q16:pae_pkg::Q16]})
                   : $signed({1'b0, p[MW+pae_pkg::Q16:pae_pkg::Q16]});
  endfunction

  logic                    cv_r [L];
  pae_pkg::pae_in_t        cp_r [L];
  logic signed [AW-1:0]    ca_r [L][3];

  logic signed [DW-1:0]    tp_x;
  logic signed [DW-1:0]    tp_y;
  logic signed [DW-1:0]    d0 [3];
  logic [DW-1:0]           m0 [3];
  logic [SQW-1:0]          m_r [3];
  logic                    far_r;
  logic [D2W-1:0]          sq_r [3];
  logic                    far1_r;
  logic [D2W+1:0]          sum;
  logic [D2W-1:0]          d2_r;
  logic [D2W+15:0]         d2s;
  logic [25:0]             xr;
  logic [51:0]             rprod;
  logic [TW-1:0]           q_r;
  logic [2*TW-1:0]         gprod;
  logic [GW-1:0]           g_r;
  logic signed [DW-1:0]    d1 [3];
  logic signed [MW-1:0]    r1_r [3];
  logic signed [MW-1:0]    tm_r [3];

  assign tp_x = $signed(DW'(slot[15:0]) << F);
  assign tp_y = $signed(DW'(slot[31:16]) << F);

  always_comb begin
    d0[0] = tp_x - DW'(in_p.pos_x);
    d0[1] = tp_y - DW'(in_p.pos_y);
    d0[2] = DW'(0) - DW'(in_p.pos_z);
    d1[0] = tp_x - DW'(cp_r[S_GAIN].pos_x);
    d1[1] = tp_y - DW'(cp_r[S_GAIN].pos_y);
    d1[2] = DW'(0) - DW'(cp_r[S_GAIN].pos_z);
    for (int k = 0; k < 3; k++) begin
      m0[k] = d0[k][DW-1] ? DW'(-d0[k]) : DW'(d0[k]);
    end
    sum = (D2W+2)'(sq_r[0]) + (D2W+2)'(sq_r[1]) + (D2W+2)'(sq_r[2]);
    d2s = {d2_r, 16'b0} >> F;
    xr = 26'(d2s >> PRE);
    rprod = 52'(xr) * 52'(RECIP);
    gprod = (2*TW)'(pae_pkg::GAIN_SPAN) * (2*TW)'(q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < L; j++) cv_r[j] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= in_v;
      for (int j = 1; j < L; j++) cv_r[j] <= cv_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_r[0] <= in_p;
      ca_r[0] <= in_acc;
      for (int j = 1; j < L; j++) cp_r[j] <= cp_r[j-1];
      for (int j = 1; j < L - 1; j++) ca_r[j] <= ca_r[j-1];
      for (int k = 0; k < 3; k++) begin
        m_r[k]  <= m0[k][SQW-1:0];
        sq_r[k] <= D2W'((2*SQW)'(m_r[k]) * (2*SQW)'(m_r[k]) >> F);
        r1_r[k] <= MW'(mq(MW'(d1[k]), g_r));
        tm_r[k] <= MW'(mq(r1_r[k], GW'(cp_r[S_M1].touch_pull)));
        ca_r[S_ACC][k] <= ca_r[S_M2][k] + (slot_en ? AW'(tm_r[k]) : AW'(0));
      end
      far_r  <= (m0[0] >= REACH) || (m0[1] >= REACH) || (m0[2] >= REACH);
      far1_r <= far_r;
      if (far1_r || sum > (D2W+2)'(HI)) begin
        d2_r <= HI;
      end else if (sum < (D2W+2)'(LO)) begin
        d2_r <= LO;
      end else begin
        d2_r <= sum[D2W-1:0];
      end
      q_r <= TW'(rprod >> RSH);
      g_r <= GW'(pae_pkg::GAIN_NEAR) - GW'(gprod >> pae_pkg::Q16);
    end
  end

  assign out_v   = cv_r[L-1];
  assign out_p   = cp_r[L-1];
  assign out_acc = ca_r[L-1];

endmodule

>>> hdl/pae_fstage.sv
// Final stage: home pull, friction, velocity update and position integration
// with saturation. Uses pae_pkg.
module pae_fstage #(
  parameter int FRAC_BITS = pae_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en,
  input  logic [15:0]                                 friction_coef,
  input  logic [15:0]                                 time_step,
  input  logic [15:0]                                 home_weight,
  input  logic                                        in_v,
  input  pae_pkg::pae_in_t                            in_p,
  input  logic signed [pae_pkg::acc_w(FRAC_BITS)-1:0] in_acc [3],
  output logic                                        out_v,
  output pae_pkg::pae_out_t                           out_d
);

  localparam int AW = pae_pkg::acc_w(FRAC_BITS);
  localparam int MW = 34;
  localparam int GW = 18;
  localparam int SW = AW + 2;
  localparam int L  = 5;

  function automatic logic signed [MW+1:0] mq(input logic signed [MW-1:0] a,
                                              input logic [GW-1:0] b);
    logic [MW-1:0]    m;
    logic [MW+GW-1:0] p;
    m = a[MW-1] ? MW'(-a) : MW'(a);
    p = (MW+GW)'(m) * (MW+GW)'(b) + (MW+GW)'(pae_pkg::ROUND_HALF);
    return a[MW-1] ? -$signed({1'b0, p[MW+pae_pkg::Q16:pae_pkg::Q16]})
                   : $signed({1'b0, p[MW+pae_pkg::Q16:pae_pkg::Q16]});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v[SW-1:31] == '0 || v[SW-1:31] == '1) begin
      return v[31:0];
    end
    return v[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  logic                 cv_r [L];
  pae_pkg::pae_in_t     cp_r [L-1];
  logic signed [MW-1:0] vel0 [3];
  logic signed [MW-1:0] dh [3];
  logic signed [MW-1:0] h1_r [3];
  logic signed [MW-1:0] fr_r [3];
  logic signed [AW-1:0] a0_r [3];
  logic signed [MW-1:0] h2_r [3];
  logic signed [MW-1:0] fr1_r [3];
  logic signed [AW-1:0] a1_r [3];
  logic signed [SW-1:0] vsum [3];
  logic signed [31:0]   nv_r [3];
  logic signed [MW-1:0] mv_r [3];
  logic signed [31:0]   nv3_r [3];
  logic signed [31:0]   nv4_r [3];
  logic signed [31:0]   np_r [3];
  logic signed [31:0]   pos3 [3];
  logic signed [31:0]   vel1 [3];

  always_comb begin
    vel0[0] = MW'(in_p.vel_x);
    vel0[1] = MW'(in_p.vel_y);
    vel0[2] = MW'(in_p.vel_z);
    dh[0]   = MW'(in_p.home_x) - MW'(in_p.pos_x);
    dh[1]   = MW'(in_p.home_y) - MW'(in_p.pos_y);
    dh[2]   = MW'(0) - MW'(in_p.pos_z);
    vel1[0] = cp_r[1].vel_x;
    vel1[1] = cp_r[1].vel_y;
    vel1[2] = cp_r[1].vel_z;
    pos3[0] = cp_r[3].pos_x;
    pos3[1] = cp_r[3].pos_y;
    pos3[2] = cp_r[3].pos_z;
    for (int k = 0; k < 3; k++) begin
      vsum[k] = SW'(vel1[k]) - SW'(fr1_r[k]) + SW'(a1_r[k]) + SW'(h2_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < L; j++) cv_r[j] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= in_v;
      for (int j = 1; j < L; j++) cv_r[j] <= cv_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_r[0] <= in_p;
      for (int j = 1; j < L - 1; j++) cp_r[j] <= cp_r[j-1];
      for (int k = 0; k < 3; k++) begin
        h1_r[k]  <= MW'(mq(dh[k], GW'(home_weight)));
        fr_r[k]  <= MW'(mq(vel0[k], GW'(friction_coef)));
        a0_r[k]  <= in_acc[k];
        h2_r[k]  <= MW'(mq(h1_r[k], GW'(cp_r[0].home_pull)));
        fr1_r[k] <= fr_r[k];
        a1_r[k]  <= a0_r[k];
        nv_r[k]  <= sat32(vsum[k]);
        mv_r[k]  <= MW'(mq(MW'(nv_r[k]), GW'(time_step)));
        nv3_r[k] <= nv_r[k];
        np_r[k]  <= sat32(SW'(pos3[k]) + SW'(mv_r[k]));
        nv4_r[k] <= nv3_r[k];
      end
    end
  end

  assign out_v           = cv_r[L-1];
  assign out_d.new_pos_x = np_r[0];
  assign out_d.new_pos_y = np_r[1];
  assign out_d.new_pos_z = np_r[2];
  assign out_d.new_vel_x = nv4_r[0];
  assign out_d.new_vel_y = nv4_r[1];
  assign out_d.new_vel_z = nv4_r[2];

endmodule

>>> hdl/particle_attractor_euler_step_core.sv
// Top level of the particle attractor Euler step core.
// Uses pae_pkg, pae_stream_if, pae_cell and pae_fstage.
//
// Usage: one particle enters per beat on in_ch (valid/ready) and one updated
// particle leaves per beat on out_ch. The user must write registers through the
// plain cfg_we / cfg_idx / cfg_wdata port only while no particle is in flight;
// the core does not enforce this. The particle passes a row of touch cells, one
// per slot up to MAX_TOUCHES and four at most. Each cell is 8 stages deep, a
// multiply by a constant reciprocal forming the distance fraction. A 5-stage
// final stage adds home pull, friction and integration, and an output register
// follows. Throughput is one particle per cycle while the skid register is
// empty, with every stage of the pipeline advancing together.
// A skid register behind the output register takes one more result while the
// receiver stalls; in_ch.ready drops while that skid register is full and
// during reset, and the whole pipeline holds until it drains.
// Synchronous reset empties the pipeline and loads the register defaults.
module particle_attractor_euler_step_core #(
  parameter int MAX_TOUCHES = pae_pkg::MAX_TOUCHES_DEF,
  parameter int FRAC_BITS   = pae_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pae_stream_if.sink                  in_ch,
  pae_stream_if.source                out_ch,
  input  logic                        cfg_we,
  input  logic [pae_pkg::CFG_AW-1:0]  cfg_idx,
  input  logic [pae_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int NCELL = (MAX_TOUCHES < pae_pkg::NUM_SLOTS) ? MAX_TOUCHES
                                                            : pae_pkg::NUM_SLOTS;
  localparam int AW    = pae_pkg::acc_w(FRAC_BITS);

  logic [15:0]                      fric_r;
  logic [15:0]                      tstep_r;
  logic [15:0]                      hweight_r;
  logic [pae_pkg::NUM_SLOTS-1:0]    ten_r;
  logic [31:0]                      slot_r [pae_pkg::NUM_SLOTS];

  logic                             en;
  logic                             ch_v [NCELL+1];
  pae_pkg::pae_in_t                 ch_p [NCELL+1];
  logic signed [AW-1:0]             ch_a [NCELL+1][3];
  logic                             fs_v;
  pae_pkg::pae_out_t                fs_d;
  logic                             out_v_r;
  pae_pkg::pae_out_t                out_r;
  logic                             sk_v_r;
  pae_pkg::pae_out_t                sk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fric_r    <= pae_pkg::FRICTION_RST;
      tstep_r   <= pae_pkg::TSTEP_RST;
      hweight_r <= pae_pkg::HWEIGHT_RST;
      ten_r     <= '0;
      for (int i = 0; i < pae_pkg::NUM_SLOTS; i++) slot_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (pae_pkg::cfg_idx_t'(cfg_idx))
        pae_pkg::CFG_FRICTION: fric_r    <= cfg_wdata[15:0];
        pae_pkg::CFG_TSTEP:    tstep_r   <= cfg_wdata[15:0];
        pae_pkg::CFG_HWEIGHT:  hweight_r <= cfg_wdata[15:0];
        pae_pkg::CFG_TENABLE:  ten_r     <= cfg_wdata[pae_pkg::NUM_SLOTS-1:0];
        pae_pkg::CFG_SLOT0:    slot_r[0] <= cfg_wdata;
        pae_pkg::CFG_SLOT1:    slot_r[1] <= cfg_wdata;
        pae_pkg::CFG_SLOT2:    slot_r[2] <= cfg_wdata;
        pae_pkg::CFG_SLOT3:    slot_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en          = !sk_v_r;
  assign in_ch.ready = en && rst_n;

  assign ch_v[0] = in_ch.valid;
  assign ch_p[0] = in_ch.data;
  assign ch_a[0] = '{default: '0};

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    pae_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .slot_en (ten_r[i]),
      .slot    (slot_r[i]),
      .in_v    (ch_v[i]),
      .in_p    (ch_p[i]),
      .in_acc  (ch_a[i]),
      .out_v   (ch_v[i+1]),
      .out_p   (ch_p[i+1]),
      .out_acc (ch_a[i+1])
    );
  end

  pae_fstage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fstage (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .friction_coef (fric_r),
    .time_step     (tstep_r),
    .home_weight   (hweight_r),
    .in_v          (ch_v[NCELL]),
    .in_p          (ch_p[NCELL]),
    .in_acc        (ch_a[NCELL]),
    .out_v         (fs_v),
    .out_d         (fs_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= fs_v;
      end
    end else if (fs_v && en) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= sk_v_r ? sk_r : fs_d;
    end else if (fs_v && en) begin
      sk_r <= fs_d;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid register holds a beat while the output register is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready && fs_v && !sk_v_r) |=> (sk_v_r && out_v_r))
    else $error("finished beat was not captured while the receiver stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (sk_v_r && out_ch.ready) |=> (!sk_v_r && out_v_r))
    else $error("skid register did not move to the output register");
`endif

endmodule

>>> bench/particle_attractor_euler_step_core_tb.sv
// Self-checking bench for particle_attractor_euler_step_core.
// Predicts each updated particle in the bench and compares the result beats in order.
// Depends on pae_pkg, pae_stream_if and the core RTL.
module particle_attractor_euler_step_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [pae_pkg::CFG_AW-1:0] cfg_idx = '0;
  logic [pae_pkg::CFG_DW-1:0] cfg_wdata = '0;

  pae_stream_if #(.T(pae_pkg::pae_in_t)) in_ch ();
  pae_stream_if #(.T(pae_pkg::pae_out_t)) out_ch ();

  particle_attractor_euler_step_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  logic [15:0] friction_r, tstep_r, hweight_r;
  logic [3:0] tenable_r;
  logic [31:0] slot_r [pae_pkg::NUM_SLOTS];

  pae_pkg::pae_out_t expected_q [$];
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit stall_on = 1'b1;

  function automatic longint mag(input longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint mul_q16(input longint a, input longint b);
    longint p;
    p = (mag(a) * b + 32768) >>> 16;
    return a < 0 ? -p : p;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint attract_gain(input longint d [3]);
    longint d2, t, m;
    bit far;
    d2 = 0;
    far = 1'b0;
    for (int k = 0; k < 3; k++) begin
      m = mag(d[k]);
      if (m >= (longint'(pae_pkg::REACH_PIX) << 16)) far = 1'b1;
      else d2 += (m * m) >>> 16;
    end
    if (far || d2 > (longint'(pae_pkg::REACH_SQ) << 16))
      d2 = longint'(pae_pkg::REACH_SQ) << 16;
    if (d2 < (64'sd1 << 16)) d2 = 64'sd1 << 16;
    t = (d2 << 16) / (longint'(pae_pkg::REACH_SQ) << 16);
    return pae_pkg::GAIN_NEAR - ((longint'(pae_pkg::GAIN_SPAN) * t) >>> 16);
  endfunction

  function automatic pae_pkg::pae_out_t euler_update(input pae_pkg::pae_in_t p);
    longint pos [3], vel [3], home [3], acc [3], d [3];
    longint g, nv, np;
    pae_pkg::pae_out_t r;
    pos = '{longint'(p.pos_x), longint'(p.pos_y), longint'(p.pos_z)};
    vel = '{longint'(p.vel_x), longint'(p.vel_y), longint'(p.vel_z)};
    home = '{longint'(p.home_x), longint'(p.home_y), 0};
    acc = '{0, 0, 0};
    for (int i = 0; i < pae_pkg::NUM_SLOTS; i++) begin
      if (tenable_r[i]) begin
        d[0] = (longint'(slot_r[i][15:0]) << 16) - pos[0];
        d[1] = (longint'(slot_r[i][31:16]) << 16) - pos[1];
        d[2] = -pos[2];
        g = attract_gain(d);
        for (int k = 0; k < 3; k++) acc[k] += mul_q16(mul_q16(d[k], g), p.touch_pull);
      end
    end
    for (int k = 0; k < 3; k++) begin
      acc[k] += mul_q16(mul_q16(home[k] - pos[k], hweight_r), p.home_pull);
      nv = clamp32(vel[k] - mul_q16(vel[k], friction_r) + acc[k]);
      np = clamp32(pos[k] + mul_q16(nv, tstep_r));
      vel[k] = nv;
      pos[k] = np;
    end
    r.new_pos_x = pos[0][31:0];
    r.new_pos_y = pos[1][31:0];
    r.new_pos_z = pos[2][31:0];
    r.new_vel_x = vel[0][31:0];
    r.new_vel_y = vel[1][31:0];
    r.new_vel_z = vel[2][31:0];
    return r;
  endfunction

  function automatic int rand_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (stall_on && $urandom_range(0, 3) == 0) begin
        gap = rand_gap() + 1;
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pae_pkg::pae_out_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", out_ch.data);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r !== out_ch.data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at result %0d: expected %p, got %p",
                     beats_out, exp_r, out_ch.data);
        end
      end
    end
  end

  task automatic write_reg(input pae_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pae_pkg::CFG_FRICTION: friction_r = val[15:0];
      pae_pkg::CFG_TSTEP: tstep_r = val[15:0];
      pae_pkg::CFG_HWEIGHT: hweight_r = val[15:0];
      pae_pkg::CFG_TENABLE: tenable_r = val[3:0];
      default: slot_r[int'(idx) - int'(pae_pkg::CFG_SLOT0)] = val;
    endcase
    @(posedge clk);
  endtask

  task automatic send_particle(input pae_pkg::pae_in_t p, input bit with_gaps);
    int gap;
    gap = with_gaps ? rand_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q = {expected_q, euler_update(p)};
    beats_in++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 ^ ($urandom_range(0, 3));
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 800 << 16)) - (400 << 16));
      3: return {16'($urandom_range(0, 600)), 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Positions often near a randomly chosen touch slot, enabled or not, so that the gain ramp is exercised.
  function automatic pae_pkg::pae_in_t rand_particle();
    pae_pkg::pae_in_t p;
    int s;
    p.pos_x = rand_word(); p.pos_y = rand_word(); p.pos_z = rand_word();
    p.vel_x = rand_word(); p.vel_y = rand_word(); p.vel_z = rand_word();
    p.home_x = rand_word(); p.home_y = rand_word();
    if ($urandom_range(0, 2) != 0) begin
      s = $urandom_range(0, pae_pkg::NUM_SLOTS - 1);
      p.pos_x = {slot_r[s][15:0], 16'h0} + 32'($signed($urandom_range(0, 500 << 16))
                - (250 << 16));
      p.pos_y = {slot_r[s][31:16], 16'h0} + 32'($signed($urandom_range(0, 500 << 16))
                - (250 << 16));
      p.pos_z = 32'($signed($urandom_range(0, 300 << 16)) - (150 << 16));
    end
    p.home_pull = 16'($urandom);
    p.touch_pull = 16'($urandom);
    if ($urandom_range(0, 9) == 0) p.home_pull = '1;
    if ($urandom_range(0, 9) == 0) p.touch_pull = '1;
    return p;
  endfunction

  task automatic test_directed();
    pae_pkg::pae_in_t p;
    logic [31:0] ext [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    write_reg(pae_pkg::CFG_SLOT0, 32'h0064_0064);
    write_reg(pae_pkg::CFG_SLOT1, 32'hFFFF_FFFF);
    write_reg(pae_pkg::CFG_SLOT2, 32'h0000_0000);
    write_reg(pae_pkg::CFG_SLOT3, 32'h012C_00C8);
    write_reg(pae_pkg::CFG_TENABLE, 32'h0000_000F);
    for (int i = 0; i < 4; i++) begin
      p = '{ext[i], ext[i], ext[i], ext[3 - i], ext[3 - i], ext[i],
            ext[(i + 1) % 4], ext[(i + 2) % 4], 16'hFFFF, 16'hFFFF};
      send_particle(p, 1'b0);
    end
    // Particle sitting exactly on a touch point, then just inside and outside reach, then just above the point.
    p = '{32'h0064_0000, 32'h0064_0000, 0, 0, 0, 0, 0, 0, 16'h8000, 16'hFFFF};
    send_particle(p, 1'b0);
    p.pos_x = 32'h0064_0000 - (199 << 16);
    send_particle(p, 1'b0);
    p.pos_x = 32'h0064_0000 - (200 << 16);
    send_particle(p, 1'b0);
    p.pos_z = 32'h0001_0000; p.pos_x = 32'h0064_0000;
    send_particle(p, 1'b0);
    p = '{32'h0001_8000, 32'hFFFE_8000, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 16'h0};
    send_particle(p, 1'b0);
    for (int i = 0; i < 10; i++) send_particle(rand_particle(), 1'b0);
    drain();
  endtask

  task automatic test_config_sweep();
    logic [15:0] q16_vals [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(pae_pkg::CFG_FRICTION, 32'(ph < 4 ? q16_vals[ph] : 16'($urandom)));
      write_reg(pae_pkg::CFG_TSTEP, 32'(ph < 4 ? q16_vals[3 - ph] : 16'($urandom)));
      write_reg(pae_pkg::CFG_HWEIGHT,
                32'(ph < 4 ? q16_vals[(ph + 1) % 4] : 16'($urandom)));
      write_reg(pae_pkg::CFG_TENABLE, 32'(ph == 0 ? 4'h0 : 4'($urandom)));
      for (int s = 0; s < pae_pkg::NUM_SLOTS; s++)
        write_reg(pae_pkg::cfg_idx_t'(int'(pae_pkg::CFG_SLOT0) + s),
                  ph == 1 ? 32'hFFFF_FFFF : {16'($urandom_range(0, 700)),
                                             16'($urandom_range(0, 700))});
      for (int i = 0; i < 200; i++) send_particle(rand_particle(), 1'b1);
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_reg(pae_pkg::CFG_TENABLE, 32'h0000_000F);
    hold_off = 1'b1;
    fork
      for (int i = 0; i < 150; i++) send_particle(rand_particle(), 1'b0);
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_no_stall();
    stall_on = 1'b0;
    for (int i = 0; i < 80; i++) send_particle(rand_particle(), 1'b0);
    stall_on = 1'b1;
    drain();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    friction_r = pae_pkg::FRICTION_RST;
    tstep_r = pae_pkg::TSTEP_RST;
    hweight_r = pae_pkg::HWEIGHT_RST;
    tenable_r = '0;
    for (int s = 0; s < pae_pkg::NUM_SLOTS; s++) slot_r[s] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 8; i++) send_particle(rand_particle(), 1'b1);
    drain();
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_no_stall();
    $display("Sent %0d particles and checked %0d result beats over %0d cycles,",
             beats_in, beats_out, cycles);
    $display("covering register extremes, touch reach edges and output stalls.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, results missing: %0d", mismatches, expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> filelist.f
hdl/pae_pkg.sv
hdl/pae_stream_if.sv
hdl/pae_cell.sv
hdl/pae_fstage.sv
hdl/particle_attractor_euler_step_core.sv
bench/particle_attractor_euler_step_core_tb.sv
